[design/scfp_pkg.sv]
// Package: shared constants, codes and types of the frame parser
`timescale 1ns / 1ps
`default_nettype none

package scfp_pkg;

  localparam int PAYLOAD_DEPTH = 1024;
  localparam int ADDR_W        = $clog2(PAYLOAD_DEPTH);
  localparam int LEN_W         = 11;
  localparam int TIME_W        = 48;
  localparam int IDX_W         = 10;
  localparam int EV_W          = 3;

  localparam logic [7:0] HDR_BYTE = 8'hDB;
  localparam logic [7:0] FTR_BYTE = 8'hDC;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_CMD,
    PH_FRAME,
    PH_PAYLOAD,
    PH_SUM,
    PH_FOOTER
  } phase_t;

  typedef enum logic [EV_W-1:0] {
    EV_NONE,
    EV_OK,
    EV_SUM_BAD,
    EV_FOOTER_BAD,
    EV_TOO_LONG
  } event_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

  typedef struct packed {
    event_t             event_res;
    logic [7:0]         command_code;
    logic [7:0]         frame_count;
    logic [LEN_W-1:0]   payload_length;
    logic [TIME_W-1:0]  frame_time;
  } step_res_t;

endpackage

`default_nettype wire

[design/scfp_in_if.sv]
// Interface: input item channel of the frame parser
`timescale 1ns / 1ps
`default_nettype none

interface scfp_in_if;
  import scfp_pkg::*;

  logic              valid;
  logic              ready;
  logic              operation;
  logic [7:0]        rx_byte;
  logic [TIME_W-1:0] arrival_time;
  logic [IDX_W-1:0]  read_index;

  modport source (
    output valid, operation, rx_byte, arrival_time, read_index,
    input  ready
  );

  modport sink (
    input  valid, operation, rx_byte, arrival_time, read_index,
    output ready
  );
endinterface

`default_nettype wire

[design/scfp_out_if.sv]
// Interface: result channel of the frame parser
`timescale 1ns / 1ps
`default_nettype none

interface scfp_out_if;
  import scfp_pkg::*;

  logic              valid;
  logic              ready;
  logic [EV_W-1:0]   event_res;
  logic [7:0]        command_code;
  logic [7:0]        frame_count;
  logic [LEN_W-1:0]  payload_length;
  logic [TIME_W-1:0] frame_time;
  logic [7:0]        read_data;

  modport source (
    output valid, event_res, command_code, frame_count, payload_length, frame_time,
           read_data,
    input  ready
  );

  modport sink (
    input  valid, event_res, command_code, frame_count, payload_length, frame_time,
           read_data,
    output ready
  );
endinterface

`default_nettype wire

[design/sum_checked_frame_parser_core.sv]
// Top level: sum-checked frame parser with payload store and result pipeline
// Pipeline: an item's result passes the stage register (store read), then the output register.
// Throughput: one item per cycle; each item makes at most one store access, a write for a
// payload byte or a read for a read operation; ready drops only while both stages are full.
// Reset: rst clears the phase, the frame fields and the pipeline valid bits at once.
// The payload store is not cleared; the user must read an entry only after it was written (not enforced).
`timescale 1ns / 1ps
`default_nettype none

module sum_checked_frame_parser_core import scfp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  scfp_in_if.sink    req,
  scfp_out_if.source rsp
);

  logic       accept;
  logic       s1_valid;
  logic       s1_adv;
  step_res_t  s1_res;
  logic       s1_read;
  step_res_t  step_res;
  store_wr_t  store_wr;
  logic [7:0] store_rd_data;
  logic       in_range;
  logic       out_valid;
  step_res_t  out_res;
  logic [7:0] out_rdata;

  assign s1_adv    = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_adv;
  assign accept    = req.valid && req.ready;
  assign in_range  = {1'b0, req.read_index} < LEN_W'(PAYLOAD_DEPTH);

  scfp_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .step_en      (accept && !req.operation),
    .rx_byte      (req.rx_byte),
    .arrival_time (req.arrival_time),
    .res          (step_res),
    .wr           (store_wr)
  );

  scfp_store u_store (
    .clk     (clk),
    .wr      (store_wr),
    .rd_en   (accept && req.operation),
    .rd_addr (req.read_index[ADDR_W-1:0]),
    .rd_data (store_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res  <= step_res;
      s1_read <= req.operation && in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res   <= s1_res;
      out_rdata <= s1_read ? store_rd_data : 8'h00;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.event_res      = EV_W'(out_res.event_res);
  assign rsp.command_code   = out_res.command_code;
  assign rsp.frame_count    = out_res.frame_count;
  assign rsp.payload_length = out_res.payload_length;
  assign rsp.frame_time     = out_res.frame_time;
  assign rsp.read_data      = out_rdata;

  a_rd_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> $stable(store_rd_data))
    else $error("store read data changed under a stalled stage");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_res))
    else $error("stalled stage lost its result");

  a_read_quiet: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.read_data == 8'h00) || (rsp.event_res == EV_NONE))
    else $error("read data on a frame event");

  a_len_event: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.payload_length != '0) |->
      (rsp.event_res == EV_OK) || (rsp.event_res == EV_SUM_BAD) ||
      (rsp.event_res == EV_FOOTER_BAD))
    else $error("payload length without frame end");

endmodule

`default_nettype wire

[design/scfp_store.sv]
// Payload store: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none

module scfp_store import scfp_pkg::*; (
  input  logic              clk,
  input  store_wr_t         wr,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [PAYLOAD_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[design/scfp_parser.sv]
// Frame parser: phase sequencer, frame fields, checksum and store write requests
`timescale 1ns / 1ps
`default_nettype none

module scfp_parser import scfp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              step_en,
  input  logic [7:0]        rx_byte,
  input  logic [TIME_W-1:0] arrival_time,
  output step_res_t         res,
  output store_wr_t         wr
);

  phase_t            phase, phase_next;
  logic [7:0]        len_hi, len_hi_next;
  logic [LEN_W-1:0]  expected_length, expected_length_next;
  logic [LEN_W-1:0]  fill_position, fill_position_next;
  logic [7:0]        held_command, held_command_next;
  logic [7:0]        held_frame_number, held_frame_number_next;
  logic [7:0]        running_sum, running_sum_next;
  logic [7:0]        sent_sum, sent_sum_next;
  logic [TIME_W-1:0] header_time, header_time_next;

  logic [15:0]       full_length;
  logic              too_long;
  logic [LEN_W-1:0]  fill_inc;
  logic [7:0]        sum_add;

  assign full_length = {len_hi, rx_byte};
  assign too_long    = full_length > 16'(PAYLOAD_DEPTH);
  assign fill_inc    = fill_position + LEN_W'(1);
  assign sum_add     = running_sum + rx_byte;

  always_comb begin
    phase_next = phase;
    if (step_en) begin
      unique case (phase)
        PH_HEADER:  if (rx_byte == HDR_BYTE) phase_next = PH_LEN_HI;
        PH_LEN_HI:  phase_next = PH_LEN_LO;
        PH_LEN_LO:  phase_next = too_long ? PH_HEADER : PH_CMD;
        PH_CMD:     phase_next = PH_FRAME;
        PH_FRAME:   phase_next = (expected_length != '0) ? PH_PAYLOAD : PH_SUM;
        PH_PAYLOAD: if (fill_inc >= expected_length) phase_next = PH_SUM;
        PH_SUM:     phase_next = PH_FOOTER;
        PH_FOOTER:  phase_next = PH_HEADER;
        default:    phase_next = PH_HEADER;
      endcase
    end
  end

  always_comb begin
    len_hi_next            = len_hi;
    expected_length_next   = expected_length;
    fill_position_next     = fill_position;
    held_command_next      = held_command;
    held_frame_number_next = held_frame_number;
    running_sum_next       = running_sum;
    sent_sum_next          = sent_sum;
    header_time_next       = header_time;
    res.event_res          = EV_NONE;
    res.payload_length     = '0;
    wr.en                  = 1'b0;
    wr.addr                = fill_position[ADDR_W-1:0];
    wr.data                = rx_byte;
    if (step_en) begin
      unique case (phase)
        PH_HEADER: begin
          if (rx_byte == HDR_BYTE) begin
            expected_length_next = '0;
            fill_position_next   = '0;
            running_sum_next     = '0;
            header_time_next     = arrival_time;
          end
        end
        PH_LEN_HI: begin
          len_hi_next      = rx_byte;
          running_sum_next = sum_add;
        end
        PH_LEN_LO: begin
          if (too_long) begin
            res.event_res        = EV_TOO_LONG;
            expected_length_next = '0;
            fill_position_next   = '0;
            running_sum_next     = '0;
          end else begin
            expected_length_next = full_length[LEN_W-1:0];
            running_sum_next     = sum_add;
          end
        end
        PH_CMD: begin
          held_command_next = rx_byte;
          running_sum_next  = sum_add;
        end
        PH_FRAME: begin
          held_frame_number_next = rx_byte;
          running_sum_next       = sum_add;
        end
        PH_PAYLOAD: begin
          wr.en              = 1'b1;
          fill_position_next = fill_inc;
          running_sum_next   = sum_add;
        end
        PH_SUM: begin
          sent_sum_next = rx_byte;
        end
        PH_FOOTER: begin
          res.payload_length = expected_length;
          if (rx_byte != FTR_BYTE) begin
            res.event_res = EV_FOOTER_BAD;
          end else if (running_sum == sent_sum) begin
            res.event_res = EV_OK;
          end else begin
            res.event_res = EV_SUM_BAD;
          end
          expected_length_next = '0;
          fill_position_next   = '0;
          running_sum_next     = '0;
        end
        default: begin
          expected_length_next = '0;
          fill_position_next   = '0;
          running_sum_next     = '0;
        end
      endcase
    end
    res.command_code = held_command_next;
    res.frame_count  = held_frame_number_next;
    res.frame_time   = header_time_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEADER;
      len_hi            <= '0;
      expected_length   <= '0;
      fill_position     <= '0;
      held_command      <= '0;
      held_frame_number <= '0;
      running_sum       <= '0;
      sent_sum          <= '0;
      header_time       <= '0;
    end else begin
      phase             <= phase_next;
      len_hi            <= len_hi_next;
      expected_length   <= expected_length_next;
      fill_position     <= fill_position_next;
      held_command      <= held_command_next;
      held_frame_number <= held_frame_number_next;
      running_sum       <= running_sum_next;
      sent_sum          <= sent_sum_next;
      header_time       <= header_time_next;
    end
  end

endmodule

`default_nettype wire
